[rtl/recf_pkg.sv]
// Package with shared widths, constants and control types for the radial energy cutoff finder.
`timescale 1ns / 1ps
package recf_pkg;

    localparam int MAX_SIDE    = 512;
    localparam int SAMPLE_BITS = 16;
    localparam int NUM_BINS    = MAX_SIDE / 2;
    localparam int MIN_SIDE    = 4;
    localparam int ONE_Q16     = 65536;

    localparam int SIDE_W  = 10;
    localparam int INDEX_W = 9;
    localparam int BIN_W   = 8;
    localparam int FRAC_W  = 17;
    localparam int ACC_W   = 40;
    localparam int HALF_W  = ACC_W / 2;
    localparam int DIST_W  = 20;
    localparam int ROOT_W  = 10;
    localparam int TGT_W   = FRAC_W + ACC_W;
    localparam int RAD_W   = 8;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRACTION = 2'd2;

    localparam logic [SIDE_W-1:0] WIDTH_RESET    = 10'd512;
    localparam logic [SIDE_W-1:0] HEIGHT_RESET   = 10'd512;
    localparam logic [FRAC_W-1:0] FRACTION_RESET = 17'd62259;

    typedef struct packed {
        logic take_pixel;
        logic square;
        logic root_step;
        logic bin_read;
        logic bin_write;
        logic target_lo;
        logic target_hi;
        logic walk_read;
        logic walk_check;
        logic publish;
    } recf_cmd_t;

    typedef struct packed {
        logic last_pixel;
        logic root_last;
        logic no_radius;
        logic walk_pass;
        logic walk_end;
        logic out_free;
    } recf_status_t;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_SQUARE = 10'b0000000010,
        ST_ROOT   = 10'b0000000100,
        ST_BREAD  = 10'b0000001000,
        ST_BWRITE = 10'b0000010000,
        ST_TGT_LO = 10'b0000100000,
        ST_TGT_HI = 10'b0001000000,
        ST_WREAD  = 10'b0010000000,
        ST_WCHECK = 10'b0100000000,
        ST_FINISH = 10'b1000000000
    } recf_state_t;

endpackage

[rtl/recf_pixel_if.sv]
// Request channel carrying one magnitude sample per request.
`timescale 1ns / 1ps
interface recf_pixel_if;
    import recf_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] magnitude;

    modport source (output valid, output magnitude, input ready);
    modport sink (input valid, input magnitude, output ready);
endinterface

[rtl/recf_result_if.sv]
// Request channel carrying the cutoff radius found for one frame.
`timescale 1ns / 1ps
interface recf_result_if;
    import recf_pkg::*;
    logic             valid;
    logic             ready;
    logic [RAD_W-1:0] cutoff_radius;
    logic             fraction_reached;

    modport source (output valid, output cutoff_radius, output fraction_reached, input ready);
    modport sink (input valid, input cutoff_radius, input fraction_reached, output ready);
endinterface

[rtl/recf_controller.sv]
// Sequencer that steps the datapath through pixel binning and the end-of-frame radius walk.
`timescale 1ns / 1ps
module recf_controller
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  recf_pkg::recf_status_t status,
    output recf_pkg::recf_cmd_t    cmd
);
    import recf_pkg::*;

    recf_state_t state_reg;
    recf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_pixel = 1'b1;
                    state_next     = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_last)
                begin
                    state_next = ST_BREAD;
                end
            end
            ST_BREAD:
            begin
                cmd.bin_read = 1'b1;
                state_next   = ST_BWRITE;
            end
            ST_BWRITE:
            begin
                cmd.bin_write = 1'b1;
                state_next    = status.last_pixel ? ST_TGT_LO : ST_IDLE;
            end
            ST_TGT_LO:
            begin
                cmd.target_lo = 1'b1;
                state_next    = ST_TGT_HI;
            end
            ST_TGT_HI:
            begin
                cmd.target_hi = 1'b1;
                state_next    = status.no_radius ? ST_FINISH : ST_WREAD;
            end
            ST_WREAD:
            begin
                cmd.walk_read = 1'b1;
                state_next    = ST_WCHECK;
            end
            ST_WCHECK:
            begin
                cmd.walk_check = 1'b1;
                if (status.walk_pass || status.walk_end)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_WREAD;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/recf_datapath.sv]
// Datapath: pixel counters, squared distance, iterative root, bin memory and radius walk.
`timescale 1ns / 1ps
module recf_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [recf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [recf_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  logic [recf_pkg::SAMPLE_BITS-1:0]  magnitude,
    input  recf_pkg::recf_cmd_t               cmd,
    output recf_pkg::recf_status_t            status,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [recf_pkg::RAD_W-1:0]        cutoff_radius,
    output logic                              fraction_reached
);
    import recf_pkg::*;

    logic [SIDE_W-1:0]      width_reg;
    logic [SIDE_W-1:0]      height_reg;
    logic [FRAC_W-1:0]      fraction_reg;
    logic [INDEX_W-1:0]     col_reg;
    logic [INDEX_W-1:0]     row_reg;
    logic [ACC_W-1:0]       total_reg;
    logic [INDEX_W-1:0]     dx_reg;
    logic [INDEX_W-1:0]     dy_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic                   last_reg;
    logic [DIST_W-1:0]      rem_reg;
    logic [DIST_W-1:0]      root_reg;
    logic [DIST_W-1:0]      bit_reg;
    logic [BIN_W-1:0]       bin_reg;
    logic                   bin_ok_reg;
    logic [ACC_W-1:0]       mem_q_reg;
    logic [NUM_BINS-1:0]    bin_valid_reg;
    logic [TGT_W-1:0]       target_reg;
    logic [ACC_W-1:0]       sum_reg;
    logic [RAD_W-1:0]       radius_reg;
    logic [RAD_W-1:0]       res_radius_reg;
    logic                   res_reached_reg;
    logic                   out_valid_reg;
    logic [RAD_W-1:0]       out_radius_reg;
    logic                   out_reached_reg;

    logic [ACC_W-1:0] bin_mem [NUM_BINS];

    logic [SIDE_W-1:0]  w_sat;
    logic [SIDE_W-1:0]  h_sat;
    logic [INDEX_W-1:0] cx;
    logic [INDEX_W-1:0] cy;
    logic [INDEX_W-1:0] lim;
    logic               last_col;
    logic               last_row;
    logic [FRAC_W-1:0]  frac_sat;
    logic [DIST_W-1:0]  trial;
    logic [ROOT_W:0]    bin_full;
    logic [BIN_W-1:0]   rd_addr;
    logic [ACC_W-1:0]   walk_val;
    logic [ACC_W-1:0]   sum_next;
    logic               pass;
    logic [TGT_W-1:0]   prod_lo;
    logic [TGT_W-1:0]   prod_hi;

    always_comb
    begin
        priority if (width_reg < SIDE_W'(MIN_SIDE))
            w_sat = SIDE_W'(MIN_SIDE);
        else if (width_reg > SIDE_W'(MAX_SIDE))
            w_sat = SIDE_W'(MAX_SIDE);
        else
            w_sat = width_reg;
        priority if (height_reg < SIDE_W'(MIN_SIDE))
            h_sat = SIDE_W'(MIN_SIDE);
        else if (height_reg > SIDE_W'(MAX_SIDE))
            h_sat = SIDE_W'(MAX_SIDE);
        else
            h_sat = height_reg;
    end

    assign cx       = w_sat[SIDE_W-1:1];
    assign cy       = h_sat[SIDE_W-1:1];
    assign lim      = (cx < cy) ? cx : cy;
    assign last_col = ({1'b0, col_reg} + 1'b1) >= w_sat;
    assign last_row = ({1'b0, row_reg} + 1'b1) >= h_sat;
    assign frac_sat = (fraction_reg > FRAC_W'(ONE_Q16)) ? FRAC_W'(ONE_Q16) : fraction_reg;

    assign trial    = root_reg + bit_reg;
    assign bin_full = {1'b0, root_reg[ROOT_W-1:0]} + 1'b1;
    assign rd_addr  = cmd.walk_read ? radius_reg : bin_full[BIN_W-1:0];
    assign walk_val = bin_valid_reg[radius_reg] ? mem_q_reg : '0;
    assign sum_next = sum_reg + walk_val;
    // Energy test without division: sum scaled to Q16 against fraction times total.
    assign pass     = {1'b0, sum_next, 16'b0} >= target_reg;
    assign prod_lo  = TGT_W'({{HALF_W{1'b0}}, frac_sat}
                             * {{FRAC_W{1'b0}}, total_reg[HALF_W-1:0]});
    assign prod_hi  = TGT_W'({{HALF_W{1'b0}}, frac_sat}
                             * {{FRAC_W{1'b0}}, total_reg[ACC_W-1:HALF_W]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            fraction_reg <= FRACTION_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:    width_reg    <= cfg_data[SIDE_W-1:0];
                REG_HEIGHT:   height_reg   <= cfg_data[SIDE_W-1:0];
                REG_FRACTION: fraction_reg <= cfg_data[FRAC_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            total_reg       <= '0;
            last_reg        <= 1'b0;
            bin_valid_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.take_pixel)
            begin
                total_reg <= total_reg + ACC_W'(magnitude);
                last_reg  <= last_col && last_row;
                if (!last_col)
                begin
                    col_reg <= col_reg + 1'b1;
                end
                else
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + 1'b1;
                end
            end
            if (cmd.bin_write && bin_ok_reg)
            begin
                bin_valid_reg[bin_reg] <= 1'b1;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= '0;
                bin_valid_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_pixel)
        begin
            dx_reg  <= (col_reg >= cx) ? col_reg - cx : cx - col_reg;
            dy_reg  <= (row_reg >= cy) ? row_reg - cy : cy - row_reg;
            mag_reg <= magnitude;
        end
        if (cmd.square)
        begin
            rem_reg  <= DIST_W'(dx_reg) * DIST_W'(dx_reg) + DIST_W'(dy_reg) * DIST_W'(dy_reg);
            root_reg <= '0;
            bit_reg  <= DIST_W'(1) << (DIST_W - 2);
        end
        if (cmd.root_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.bin_read)
        begin
            bin_reg    <= bin_full[BIN_W-1:0];
            bin_ok_reg <= (bin_full < (ROOT_W+1)'(NUM_BINS));
        end
        if (cmd.bin_read || cmd.walk_read)
        begin
            mem_q_reg <= bin_mem[rd_addr];
        end
        if (cmd.bin_write && bin_ok_reg)
        begin
            bin_mem[bin_reg] <= (bin_valid_reg[bin_reg] ? mem_q_reg : '0) + ACC_W'(mag_reg);
        end
        if (cmd.target_lo)
        begin
            target_reg <= prod_lo;
        end
        if (cmd.target_hi)
        begin
            target_reg      <= target_reg + (prod_hi << HALF_W);
            sum_reg         <= '0;
            radius_reg      <= RAD_W'(1);
            res_radius_reg  <= RAD_W'(1);
            res_reached_reg <= 1'b0;
        end
        if (cmd.walk_check)
        begin
            sum_reg    <= sum_next;
            radius_reg <= radius_reg + 1'b1;
            if (pass)
            begin
                res_radius_reg  <= radius_reg;
                res_reached_reg <= 1'b1;
            end
        end
        if (cmd.publish)
        begin
            out_radius_reg  <= res_radius_reg;
            out_reached_reg <= res_reached_reg;
        end
    end

    assign status.last_pixel = last_reg;
    assign status.root_last  = bit_reg[0];
    assign status.no_radius  = (lim <= INDEX_W'(1));
    assign status.walk_pass  = pass;
    assign status.walk_end   = ({1'b0, radius_reg} + 1'b1) >= lim;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign cutoff_radius    = out_radius_reg;
    assign fraction_reached = out_reached_reg;

endmodule

[rtl/radial_energy_cutoff_finder.sv]
// Top level of the radial energy cutoff finder.
`timescale 1ns / 1ps
// Usage:
// Magnitude samples of a frame arrive in row-major order on the pixel channel,
// one per request. Each sample is accepted, its center distance is squared,
// ten steps of the shared bit-pair square root unit run, and the single-port
// bin memory is read and then written; a new pixel is accepted only when the
// previous one is binned. After the last pixel of a frame the energy target is
// formed from a low and a high partial product, then the bins are walked from
// radius 1 upward (memory read, then add and compare) until the fraction is
// reached or the radius reaches min(width, height) / 2 - 1; the result request
// then appears on the result channel. The result sits in an output register;
// the next frame's pixels are taken while it waits. If the receiver still
// stalls when the next frame ends, the block holds in its final state until
// the earlier result is taken. Reset restores the register defaults, clears
// the counters, the total and the bin valid flags; no clearing pass is needed.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so only while the block is idle, which the block does not enforce.
module radial_energy_cutoff_finder
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [recf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [recf_pkg::CFG_DAT_W-1:0] cfg_data,
    recf_pixel_if.sink                     pixel,
    recf_result_if.source                  result
);
    import recf_pkg::*;

    recf_cmd_t    cmd;
    recf_status_t status;

    recf_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .in_ready (pixel.ready),
        .status   (status),
        .cmd      (cmd)
    );

    recf_datapath u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .magnitude        (pixel.magnitude),
        .cmd              (cmd),
        .status           (status),
        .out_ready        (result.ready),
        .out_valid        (result.valid),
        .cutoff_radius    (result.cutoff_radius),
        .fraction_reached (result.fraction_reached)
    );

endmodule
